// File: rtl/core/fingertip_click_classifier_top_macros.svh
// assertion helpers included by fingertip_click_classifier_top.sv
`ifndef FINGERTIP_CLICK_CLASSIFIER_TOP_MACROS_SVH
`define FINGERTIP_CLICK_CLASSIFIER_TOP_MACROS_SVH

// same-cycle implication, quiet during reset
`define FCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define FCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/fcc_pkg.sv
`default_nettype none

package fcc_pkg;

  localparam int CoordW = 12;

  localparam logic [2:0] RUN_MAX         = 3'd5;
  localparam logic [2:0] SYM_MAX         = 3'd6;
  localparam logic [2:0] OUTSIDE_MIN_RUN = 3'd5;

  typedef enum logic [1:0] {
    REG_BOX_LEFT   = 2'd0,
    REG_BOX_TOP    = 2'd1,
    REG_BOX_WIDTH  = 2'd2,
    REG_BOX_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CLICK_NONE   = 2'd0,
    CLICK_SINGLE = 2'd1,
    CLICK_DOUBLE = 2'd2
  } click_kind_t;

  typedef struct packed {
    logic [CoordW-1:0] left;
    logic [CoordW-1:0] top;
    logic [CoordW-1:0] width;
    logic [CoordW-1:0] height;
  } box_t;

endpackage

`default_nettype wire

// File: rtl/core/fcc_box_test.sv
`default_nettype none

module fcc_box_test
  import fcc_pkg::*;
(
  input  box_t              box,
  input  logic [CoordW-1:0] x,
  input  logic [CoordW-1:0] y,
  output logic              hit
);

  logic [CoordW:0] right_edge;
  logic [CoordW:0] bottom_edge;

  // far edges are one bit wider so they never wrap
  assign right_edge  = {1'b0, box.left} + {1'b0, box.width};
  assign bottom_edge = {1'b0, box.top} + {1'b0, box.height};

  assign hit = (x >= box.left) && ({1'b0, x} <= right_edge) &&
               (y >= box.top)  && ({1'b0, y} <= bottom_edge);

endmodule

`default_nettype wire

// File: rtl/core/fingertip_click_classifier_top.sv
// channel  | direction | beat fields                  | handshake
// ---------+-----------+------------------------------+----------------------
// in       | input     | tip_x, tip_y, last_point     | in_valid / in_ready
// out      | output    | click_kind                   | out_valid / out_ready
// cfg      | input     | cfg_index, cfg_data          | cfg_valid / cfg_ready
//
// one point per cycle sustained while no last point waits on a full
// result register; a point sits in the input register, and at the edge
// that empties it the run tracker updates and a last point loads the
// result register, which holds the click result. a waiting result only
// stalls a following last point, which then holds back the points behind
// it. rst is synchronous and clears the box registers, the run tracker
// and both valid flags. cfg_ready is always high.
`default_nettype none

module fingertip_click_classifier_top
  import fcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // point channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CoordW-1:0] tip_x,
  input  logic [CoordW-1:0] tip_y,
  input  logic              last_point,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        click_kind,
  // configuration channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [CoordW-1:0] cfg_data
);

`include "fingertip_click_classifier_top_macros.svh"

  // box registers
  box_t box;

  // input register
  logic              pt_valid;
  logic [CoordW-1:0] pt_x;
  logic [CoordW-1:0] pt_y;
  logic              pt_last;

  // run tracker state
  logic       started;
  logic       inside_prev;
  logic [2:0] run_length;
  logic       first_symbol;
  logic [2:0] symbol_count;

  // result register
  click_kind_t kind;

  logic pt_hit;
  logic consume;

  // run tracker next values
  logic       started_next;
  logic       inside_prev_next;
  logic [2:0] run_length_next;
  logic       first_symbol_next;
  logic [2:0] symbol_count_next;
  // after the final-run symbol on a last point
  logic       first_fin;
  logic [2:0] count_fin;
  logic       final_adds;
  click_kind_t kind_next;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      box <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_BOX_LEFT:   box.left   <= cfg_data;
        REG_BOX_TOP:    box.top    <= cfg_data;
        REG_BOX_WIDTH:  box.width  <= cfg_data;
        REG_BOX_HEIGHT: box.height <= cfg_data;
        default: ;
      endcase
    end
  end

  // a point leaves the input register unless it is a last point
  // and the result register is still full
  assign consume  = pt_valid && (!pt_last || !out_valid || out_ready);
  assign in_ready = !pt_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_valid <= 1'b0;
    end else if (in_ready) begin
      pt_valid <= in_valid;
    end
  end

  // point payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pt_x    <= tip_x;
      pt_y    <= tip_y;
      pt_last <= last_point;
    end
  end

  fcc_box_test u_box_test (
    .box (box),
    .x   (pt_x),
    .y   (pt_y),
    .hit (pt_hit)
  );

  // run and symbol update for one point
  always_comb begin
    started_next      = 1'b1;
    inside_prev_next  = inside_prev;
    run_length_next   = run_length;
    first_symbol_next = first_symbol;
    symbol_count_next = symbol_count;
    if (!started) begin
      // first point of a sequence opens a run
      inside_prev_next = pt_hit;
      run_length_next  = 3'd1;
    end else if (pt_hit == inside_prev) begin
      if (run_length < RUN_MAX) begin
        run_length_next = run_length + 3'd1;
      end
    end else begin
      // run ended: it becomes a symbol, a new run starts
      if (symbol_count == 3'd0) begin
        first_symbol_next = inside_prev;
      end
      if (symbol_count < SYM_MAX) begin
        symbol_count_next = symbol_count + 3'd1;
      end
      inside_prev_next = pt_hit;
      run_length_next  = 3'd1;
    end
  end

  // final run only counts if long enough
  always_comb begin
    final_adds = (!inside_prev_next && (run_length_next >= OUTSIDE_MIN_RUN)) ||
                 (inside_prev_next && (run_length_next > 3'd1));
    first_fin  = first_symbol_next;
    count_fin  = symbol_count_next;
    if (final_adds) begin
      if (symbol_count_next == 3'd0) begin
        first_fin = inside_prev_next;
      end
      if (symbol_count_next < SYM_MAX) begin
        count_fin = symbol_count_next + 3'd1;
      end
    end
  end

  // 10 / 010 single, 1010 / 01010 double
  always_comb begin
    kind_next = CLICK_NONE;
    if ((count_fin == 3'd2 && first_fin) || (count_fin == 3'd3 && !first_fin)) begin
      kind_next = CLICK_SINGLE;
    end else if ((count_fin == 3'd4 && first_fin) ||
                 (count_fin == 3'd5 && !first_fin)) begin
      kind_next = CLICK_DOUBLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started      <= 1'b0;
      inside_prev  <= 1'b0;
      run_length   <= '0;
      first_symbol <= 1'b0;
      symbol_count <= '0;
    end else if (consume) begin
      if (pt_last) begin
        // sequence done, tracker starts over
        started      <= 1'b0;
        inside_prev  <= 1'b0;
        run_length   <= '0;
        first_symbol <= 1'b0;
        symbol_count <= '0;
      end else begin
        started      <= started_next;
        inside_prev  <= inside_prev_next;
        run_length   <= run_length_next;
        first_symbol <= first_symbol_next;
        symbol_count <= symbol_count_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (consume && pt_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && pt_last) begin
      kind <= kind_next;
    end
  end

  assign click_kind = kind;

  // a last point always yields a result and an idle tracker
  `FCC_ASSERT_NEXT(a_last_clears, consume && pt_last, out_valid && !started,
                   "last point did not produce a result or clear the tracker")
  // an idle tracker holds no run and no symbols
  `FCC_ASSERT_NOW(a_idle_empty, !started,
                  run_length == 3'd0 && symbol_count == 3'd0,
                  "tracker idle with leftover run or symbols")
  // an ordinary point leaves the tracker running
  `FCC_ASSERT_NEXT(a_mid_started, consume && !pt_last, started && run_length != 3'd0,
                   "tracker not running after a mid-sequence point")
  // counters stay within saturation limits
  `FCC_ASSERT_NOW(a_sat_limits, started,
                  run_length <= RUN_MAX && symbol_count <= SYM_MAX,
                  "run or symbol counter beyond saturation")

endmodule

`default_nettype wire
